@@ src/pcgb_pkg.sv @@
// Package for the PCG bit generator: codes, reset values and field widths.
package pcgb_pkg;

    // Field widths
    localparam int unsigned STATE_W   = 64;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned BIT_IDX_W = 5;

    // Operation codes of an input transaction
    typedef enum logic [0:0] {
        OP_DRAW = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STATE_SIZE = 3'd0,
        REG_USE_MCG    = 3'd1,
        REG_USE_RR     = 3'd2,
        REG_MULTIPLIER = 3'd3,
        REG_INCREMENT  = 3'd4
    } t_reg_idx;

    // State width selector codes; the unused code behaves as 64 bits
    typedef enum logic [1:0] {
        SIZE_16 = 2'd0,
        SIZE_32 = 2'd1,
        SIZE_64 = 2'd2,
        SIZE_64_ALT = 2'd3
    } t_size_sel;

    // Reset values
    localparam logic [STATE_W-1:0] RESET_STATE = 64'h71A5_6ADF_8323_43F1;
    localparam logic [STATE_W-1:0] RESET_MULT  = 64'h5851_F42D_4C95_7F2D;
    localparam logic [STATE_W-1:0] RESET_INC   = 64'h1405_7B7E_F767_814F;

    // Counter loads after an advance: half the state width minus one
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_16 = 5'd7;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_32 = 5'd15;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_64 = 5'd31;

endpackage

@@ src/pcgb_ifs.sv @@
// Channel interfaces of the PCG bit generator: input, result and configuration.

// Input channel: draw or seed-load transactions
interface pcgb_in_if;
    import pcgb_pkg::*;
    logic               valid;
    logic               ready;
    logic [0:0]         operation;
    logic [STATE_W-1:0] seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

// Result channel: one drawn bit per transaction
interface pcgb_out_if;
    logic valid;
    logic ready;
    logic random_bit;
    logic new_word;

    modport source (output valid, output random_bit, output new_word, input ready);
    modport sink   (input valid, input random_bit, input new_word, output ready);
endinterface

// Configuration write channel
interface pcgb_cfg_if;
    import pcgb_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [STATE_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/pcg_bit_generator.sv @@
// PCG bit generator top level: state advance, output permutation and bit stream.
//
// Channels: i_in takes draw and seed-load transactions, o_out gives one result per
// draw (random_bit, new_word), i_cfg writes the five configuration registers.
// A load gives no result; it replaces the state and restarts the bit counter.
// A draw's result is registered and appears in the cycle after acceptance.
// Throughput: one draw per cycle. The next state is computed ahead by a two-stage
// multiplier (three 32x32 partial products, then a 64-bit add with the increment)
// that restarts whenever the state or a register changes. A draw that must advance
// the state waits until that lookahead is ready, so draws can stall after reset, a
// load or a configuration write; between advances there are at least 8 draws,
// which hides the multiplier completely.
// The output register frees as it is taken, so a new draw is accepted in the same
// cycle the receiver takes the previous result. When the receiver stalls, the held
// result stays stable and draws wait; loads likewise wait while a draw is blocked.
// Reset (synchronous, active low) restores the default seed, multiplier,
// increment and 64-bit XSH-RS mode, clears the counter and empties the output.
// Configuration writes are always accepted.
module pcg_bit_generator
    import pcgb_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcgb_in_if.sink      i_in,
    pcgb_out_if.source   o_out,
    pcgb_cfg_if.sink     i_cfg
);

    // Configuration registers
    logic [1:0]         r_size_sel;
    logic               r_use_mcg;
    logic               r_use_rr;
    logic [STATE_W-1:0] r_mult;
    logic [STATE_W-1:0] r_inc;

    // Generator state
    logic [STATE_W-1:0]   r_gen_state;
    logic [WORD_W-1:0]    r_out_shift;
    logic [BIT_IDX_W-1:0] r_bit_index;

    // Lookahead pipeline
    logic [63:0]        r_p_ll;
    logic [31:0]        r_p_lh;
    logic [31:0]        r_p_hl;
    logic [STATE_W-1:0] r_next_state;
    logic [1:0]         r_age;
    logic [1:0]         n_age;

    // Output register
    logic r_out_valid;
    logic r_out_bit;
    logic r_out_new;

    logic [STATE_W-1:0]   w_mask;
    logic [STATE_W-1:0]   w_a;
    logic [STATE_W-1:0]   w_b;
    logic [STATE_W-1:0]   w_inc;
    logic [STATE_W-1:0]   n_next_state;
    logic [WORD_W-1:0]    w_word;
    logic [BIT_IDX_W-1:0] w_last_bit;
    logic [WORD_W-1:0]    n_out_shift;
    logic                 w_need_adv;
    logic                 w_in_fire;
    logic                 w_draw;
    logic                 w_load;
    logic                 w_adv;
    logic                 w_cfg_fire;

    // State width mask and counter reload
    always_comb begin
        case (t_size_sel'(r_size_sel))
            SIZE_16: begin
                w_mask     = 64'h0000_0000_0000_FFFF;
                w_last_bit = LAST_BIT_16;
            end
            SIZE_32: begin
                w_mask     = 64'h0000_0000_FFFF_FFFF;
                w_last_bit = LAST_BIT_32;
            end
            default: begin
                w_mask     = '1;
                w_last_bit = LAST_BIT_64;
            end
        endcase
    end

    assign w_a   = r_gen_state & w_mask;
    assign w_b   = r_mult & w_mask;
    assign w_inc = r_use_mcg ? '0 : (r_inc & w_mask);

    // Low 64 bits of the product from three partial products, plus increment
    assign n_next_state = (r_p_ll + {(r_p_lh + r_p_hl), 32'h0} + w_inc) & w_mask;

    // Output permutation of the lookahead state
    always_comb begin
        logic [63:0] s;
        logic [63:0] x;
        logic [15:0] x16;
        logic [31:0] x32;
        logic [63:0] x64;
        logic [6:0]  sh;
        s      = r_next_state;
        x      = '0;
        x16    = '0;
        x32    = '0;
        x64    = '0;
        sh     = '0;
        w_word = '0;
        case (t_size_sel'(r_size_sel))
            SIZE_16: begin
                if (r_use_rr) begin
                    x   = (((s >> 5) ^ s) >> 5);
                    x16 = {x[7:0], x[7:0]} >> s[15:13];
                    w_word = {24'h0, x16[7:0]};
                end else begin
                    x  = (s >> 7) ^ s;
                    sh = {5'd0, s[15:14]} + 7'd3;
                    x  = x >> sh;
                    w_word = {24'h0, x[7:0]};
                end
            end
            SIZE_32: begin
                if (r_use_rr) begin
                    x   = (((s >> 10) ^ s) >> 12);
                    x32 = {x[15:0], x[15:0]} >> s[31:28];
                    w_word = {16'h0, x32[15:0]};
                end else begin
                    x  = (s >> 11) ^ s;
                    sh = {5'd0, s[31:30]} + 7'd11;
                    x  = x >> sh;
                    w_word = {16'h0, x[15:0]};
                end
            end
            default: begin
                if (r_use_rr) begin
                    x   = (((s >> 18) ^ s) >> 27);
                    x64 = {x[31:0], x[31:0]} >> s[63:59];
                    w_word = x64[31:0];
                end else begin
                    x  = (s >> 22) ^ s;
                    sh = {4'd0, s[63:61]} + 7'd22;
                    x  = x >> sh;
                    w_word = x[31:0];
                end
            end
        endcase
    end

    // Handshakes
    assign w_need_adv = (r_bit_index == '0);
    assign i_in.ready = (!r_out_valid || o_out.ready) && (!w_need_adv || r_age == 2'd2);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_load     = w_in_fire && (t_op'(i_in.operation) == OP_LOAD);
    assign w_draw     = w_in_fire && (t_op'(i_in.operation) == OP_DRAW);
    assign w_adv      = w_draw && w_need_adv;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;

    assign n_out_shift = w_need_adv ? w_word : (r_out_shift >> 1);

    // Lookahead age: restarts whenever its inputs change
    always_comb begin
        if (w_load || w_adv || w_cfg_fire) begin
            n_age = 2'd0;
        end else if (r_age == 2'd2) begin
            n_age = r_age;
        end else begin
            n_age = r_age + 2'd1;
        end
    end

    // Lookahead multiplier stages
    always_ff @(posedge i_clk) begin
        r_p_ll       <= {32'h0, w_a[31:0]} * {32'h0, w_b[31:0]};
        r_p_lh       <= w_a[31:0] * w_b[63:32];
        r_p_hl       <= w_a[63:32] * w_b[31:0];
        r_next_state <= n_next_state;
    end

    // Configuration, generator state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_sel  <= SIZE_64;
            r_use_mcg   <= 1'b0;
            r_use_rr    <= 1'b0;
            r_mult      <= RESET_MULT;
            r_inc       <= RESET_INC;
            r_gen_state <= RESET_STATE;
            r_out_shift <= '0;
            r_bit_index <= '0;
            r_age       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_age <= n_age;
            if (w_cfg_fire) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_STATE_SIZE: r_size_sel <= i_cfg.data[1:0];
                    REG_USE_MCG:    r_use_mcg  <= i_cfg.data[0];
                    REG_USE_RR:     r_use_rr   <= i_cfg.data[0];
                    REG_MULTIPLIER: r_mult     <= i_cfg.data;
                    REG_INCREMENT:  r_inc      <= i_cfg.data;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_gen_state <= i_in.seed_value;
                r_bit_index <= '0;
            end else if (w_draw) begin
                r_out_shift <= n_out_shift;
                if (w_need_adv) begin
                    r_gen_state <= r_next_state;
                    r_bit_index <= w_last_bit;
                end else begin
                    r_bit_index <= r_bit_index - 5'd1;
                end
            end
            if (w_draw) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_out_bit <= n_out_shift[0];
            r_out_new <= w_need_adv;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.random_bit = r_out_bit;
    assign o_out.new_word   = r_out_new;

endmodule

@@ tb/tb_top.sv @@
// Testbench for the PCG bit generator: random draw/load traffic checked against a bit predictor.
`timescale 1ns / 1ps

module tb_top;
    import pcgb_pkg::*;

    localparam int unsigned CLK_HALF      = 10;
    localparam int unsigned RST_CYCLES    = 12;
    localparam int unsigned RANDOM_ITEMS  = 1750;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_INCREMENT + 1);
    localparam logic [STATE_W-1:0]   ALL_ONES = {STATE_W{1'b1}};

    // Receiver behavior per phase
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } t_rx_mode;

    typedef struct packed {
        logic random_bit;
        logic new_word;
    } t_bit_result;

    // Shadow generator: tracks state and registers, queues expected bits
    class bit_stream_board;
        t_size_sel          size_sel;
        logic               mcg_mode;
        logic               rr_mode;
        logic [STATE_W-1:0] mult;
        logic [STATE_W-1:0] incr;
        logic [STATE_W-1:0] gen_state;
        logic [WORD_W-1:0]  out_word;
        logic [BIT_IDX_W-1:0] bits_left;
        t_bit_result        expected_bits[$];
        int                 error_count;

        function new();
            size_sel    = SIZE_64;
            mcg_mode    = 1'b0;
            rr_mode     = 1'b0;
            mult        = RESET_MULT;
            incr        = RESET_INC;
            gen_state   = RESET_STATE;
            out_word    = '0;
            bits_left   = '0;
            error_count = 0;
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction

        function int unsigned state_width();
            case (size_sel)
                SIZE_16: return 16;
                SIZE_32: return 32;
                default: return 64;
            endcase
        endfunction

        function logic [63:0] low_mask(int unsigned w);
            if (w >= 64) return ALL_ONES;
            return (64'd1 << w) - 64'd1;
        endfunction

        function logic [63:0] rot_right(logic [63:0] x, int unsigned r, int unsigned bits);
            logic [63:0] m;
            m = low_mask(bits);
            x = x & m;
            r = r & (bits - 1);
            if (r == 0) return x;
            return ((x >> r) | (x << (bits - r))) & m;
        endfunction

        // XSH-RS / XSH-RR permutation down to half the state width
        function logic [WORD_W-1:0] permute(logic [63:0] s, int unsigned w);
            logic [63:0] x;
            int unsigned sh;
            if (w == 16) begin
                if (rr_mode) begin
                    x = (((s >> 5) ^ s) >> 5) & 64'hFF;
                    return WORD_W'(rot_right(x, {29'd0, s[15:13]}, 8));
                end
                x  = (s >> 7) ^ s;
                sh = s[15:14] + 3;
                return WORD_W'((x >> sh) & 64'hFF);
            end
            if (w == 32) begin
                if (rr_mode) begin
                    x = (((s >> 10) ^ s) >> 12) & 64'hFFFF;
                    return WORD_W'(rot_right(x, {28'd0, s[31:28]}, 16));
                end
                x  = (s >> 11) ^ s;
                sh = s[31:30] + 11;
                return WORD_W'((x >> sh) & 64'hFFFF);
            end
            if (rr_mode) begin
                x = (((s >> 18) ^ s) >> 27) & 64'hFFFF_FFFF;
                return WORD_W'(rot_right(x, {27'd0, s[63:59]}, 32));
            end
            x  = (s >> 22) ^ s;
            sh = s[63:61] + 22;
            return WORD_W'((x >> sh) & 64'hFFFF_FFFF);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STATE_W-1:0] data);
            case (idx)
                REG_STATE_SIZE: size_sel = t_size_sel'(data[1:0]);
                REG_USE_MCG:    mcg_mode = data[0];
                REG_USE_RR:     rr_mode  = data[0];
                REG_MULTIPLIER: mult     = data;
                REG_INCREMENT:  incr     = data;
                default: ;
            endcase
        endfunction

        // One accepted input transaction
        function void note_input(t_op op, logic [STATE_W-1:0] seed);
            int unsigned w;
            logic [63:0] m;
            logic [63:0] s;
            t_bit_result res;
            if (op == OP_LOAD) begin
                gen_state = seed;
                bits_left = '0;
                return;
            end
            if (bits_left == 0) begin
                w = state_width();
                m = low_mask(w);
                s = (gen_state & m) * (mult & m);
                if (!mcg_mode) s = s + (incr & m);
                s = s & m;
                gen_state = s;
                out_word  = permute(s, w);
                bits_left = BIT_IDX_W'((w >> 1) - 1);
                res.new_word = 1'b1;
            end else begin
                bits_left = bits_left - 1'b1;
                out_word  = out_word >> 1;
                res.new_word = 1'b0;
            end
            res.random_bit = out_word[0];
            expected_bits.push_back(res);
        endfunction

        // One accepted result transaction
        function void check_result(logic rbit, logic fresh);
            t_bit_result exp_res;
            if (expected_bits.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual bit %0b new_word %0b",
                         $time, rbit, fresh);
                error_count++;
                return;
            end
            exp_res = expected_bits.pop_front();
            if (rbit !== exp_res.random_bit) begin
                $display("%0t: random_bit mismatch: expected %0b, actual %0b",
                         $time, exp_res.random_bit, rbit);
                error_count++;
            end
            if (fresh !== exp_res.new_word) begin
                $display("%0t: new_word mismatch: expected %0b, actual %0b",
                         $time, exp_res.new_word, fresh);
                error_count++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcgb_in_if  in_bus();
    pcgb_out_if res_bus();
    pcgb_cfg_if cfg_bus();

    pcg_bit_generator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (res_bus),
        .i_cfg   (cfg_bus)
    );

    bit_stream_board board;
    t_rx_mode        rx_mode = RX_STREAM;
    int unsigned     rx_hold;
    int unsigned     rx_on_len;
    int unsigned     rx_off_len;
    int unsigned     cycle_count = 0;

    // Clock
    always #(CLK_HALF) i_clk = ~i_clk;

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver ready pattern
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
        end else begin
            case (rx_mode)
                RX_STREAM: begin
                    res_bus.ready <= 1'b1;
                end
                RX_RANDOM: begin
                    res_bus.ready <= ($urandom_range(3) != 0);
                    rx_hold = $urandom_range(2);
                end
                RX_PERIODIC: begin
                    // alternate fixed on/off stretches
                    res_bus.ready <= ~res_bus.ready;
                    rx_hold = res_bus.ready ? rx_off_len : rx_on_len;
                end
                default: begin
                    if ($urandom_range(7) == 0) begin
                        res_bus.ready <= 1'b0;
                        rx_hold = $urandom_range(20);
                    end else begin
                        res_bus.ready <= 1'b1;
                        rx_hold = $urandom_range(12);
                    end
                end
            endcase
        end
    end

    // Transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready)
                board.check_result(res_bus.random_bit, res_bus.new_word);
            if (in_bus.valid && in_bus.ready)
                board.note_input(t_op'(in_bus.operation), in_bus.seed_value);
            if (cfg_bus.valid && cfg_bus.ready)
                board.write_reg(cfg_bus.index, cfg_bus.data);
        end
    end

    task automatic send_item(input t_op op, input logic [STATE_W-1:0] seed);
        in_bus.valid      <= 1'b1;
        in_bus.operation  <= op;
        in_bus.seed_value <= seed;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    task automatic pause_input(input int unsigned n);
        in_bus.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STATE_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain: all results back, then let a trailing load finish
    task automatic settle();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [STATE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [STATE_W-1:0] pick_wide();
        case ($urandom_range(5))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return {48'd0, 16'($urandom)};
            default: return rand64();
        endcase
    endfunction

    function automatic logic [STATE_W-1:0] pick_mult();
        case ($urandom_range(6))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return RESET_MULT;
            3:       return rand64() | 64'd1;
            default: return rand64();
        endcase
    endfunction

    initial begin
        int unsigned sent;
        int unsigned n_items;
        int unsigned burst_left;
        int unsigned gap_max;
        int unsigned gap;
        logic [STATE_W-1:0] data;
        t_op op;

        board = new();
        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.operation  <= OP_DRAW;
        in_bus.seed_value <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_STATE_SIZE;
        cfg_bus.data      <= '0;
        rx_hold    = 0;
        rx_on_len  = 4;
        rx_off_len = 2;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults, extreme seeds
        send_item(OP_DRAW, ALL_ONES);
        send_item(OP_DRAW, '0);
        send_item(OP_LOAD, ALL_ONES);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, ALL_ONES);
        send_item(OP_LOAD, '0);
        send_item(OP_DRAW, '0);
        settle();

        // Directed: spare width code, MCG, XSH-RR, all-ones constants, mid-word
        write_reg(REG_STATE_SIZE, {62'd0, SIZE_64_ALT});
        write_reg(REG_USE_MCG, 64'd1);
        write_reg(REG_USE_RR, 64'd1);
        write_reg(REG_MULTIPLIER, ALL_ONES);
        write_reg(REG_INCREMENT, ALL_ONES);
        for (int k = REG_SPARE_FIRST; k < (1 << CFG_IDX_W); k++)
            write_reg(k[CFG_IDX_W-1:0], ALL_ONES);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, '0);
        settle();

        // Directed: 16-bit state with zero multiplier, seed wider than the state
        write_reg(REG_STATE_SIZE, {62'd0, SIZE_16});
        write_reg(REG_USE_MCG, 64'd0);
        write_reg(REG_USE_RR, 64'd0);
        write_reg(REG_MULTIPLIER, '0);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, '0);
        send_item(OP_LOAD, 64'hFFFF_FFFF_FFFF_1234);
        send_item(OP_DRAW, '0);
        settle();

        // Directed: 32-bit XSH-RR LCG
        write_reg(REG_STATE_SIZE, {62'd0, SIZE_32});
        write_reg(REG_USE_RR, 64'd1);
        write_reg(REG_MULTIPLIER, RESET_MULT);
        write_reg(REG_INCREMENT, '0);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, '0);
        send_item(OP_DRAW, '0);
        settle();

        // Random phases
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(1)) begin
                data = rand64();
                data[1:0] = 2'($urandom_range(3));
                write_reg(REG_STATE_SIZE, data);
            end
            if ($urandom_range(1)) write_reg(REG_USE_MCG, rand64());
            if ($urandom_range(1)) write_reg(REG_USE_RR, rand64());
            if ($urandom_range(1)) write_reg(REG_MULTIPLIER, pick_mult());
            if ($urandom_range(1)) write_reg(REG_INCREMENT, pick_wide());
            if ($urandom_range(15) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, (1 << CFG_IDX_W) - 1)),
                          rand64());

            rx_on_len  = $urandom_range(0, 6);
            rx_off_len = $urandom_range(0, 4);
            rx_mode    = t_rx_mode'($urandom_range(3));
            case ($urandom_range(2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 10;
            endcase

            n_items    = $urandom_range(16, 160);
            burst_left = $urandom_range(1, 16);
            repeat (n_items) begin
                op = ($urandom_range(24) == 0) ? OP_LOAD : OP_DRAW;
                send_item(op, pick_wide());
                sent++;
                burst_left--;
                if (burst_left == 0) begin
                    gap = $urandom_range(gap_max);
                    if (gap > 0) pause_input(gap);
                    burst_left = $urandom_range(1, 16);
                end
            end
            settle();
        end

        if (board.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
